// ===== hdl/onms_pkg.sv =====
// ---------------------------------------------------------------------------
// onms_pkg: shared definitions for oriented non-maximum suppression
// Widths, register indexes, sector codes and the word types that pass between
// the stages of the suppression pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package onms_pkg;

   localparam int MAX_WIDTH        = 1024;
   localparam int SAMPLE_BITS      = 16;
   localparam int WEIGHT_FRAC_BITS = 16;

   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int ROW_BITS     = 10;
   localparam int HEIGHT_LIMIT = 1 << ROW_BITS;
   localparam int DIM_BITS     = 11;

   localparam int WCMP_BITS = (DIM_BITS > COL_BITS + 1) ? DIM_BITS : COL_BITS + 1;
   localparam int HCMP_BITS = (DIM_BITS > ROW_BITS + 1) ? DIM_BITS : ROW_BITS + 1;

   localparam int SECTOR_BITS     = 3;
   localparam int WEIGHT_REG_BITS = 17;
   localparam int WSAT_BITS       = (WEIGHT_REG_BITS > WEIGHT_FRAC_BITS + 1) ?
                                    WEIGHT_REG_BITS : WEIGHT_FRAC_BITS + 1;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH      = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT     = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIRECTION_SECTOR = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_INTERP_WEIGHT    = CSR_INDEX_BITS'(3);

   localparam logic [SECTOR_BITS-1:0] SECTOR_0 = SECTOR_BITS'(0);
   localparam logic [SECTOR_BITS-1:0] SECTOR_1 = SECTOR_BITS'(1);
   localparam logic [SECTOR_BITS-1:0] SECTOR_2 = SECTOR_BITS'(2);
   localparam logic [SECTOR_BITS-1:0] SECTOR_3 = SECTOR_BITS'(3);

   localparam int LANES         = 4;
   localparam int LANE_CNT_BITS = $clog2(LANES + 1);
   localparam int FIFO_PTR_BITS = 4;
   localparam int FIFO_DEPTH    = 1 << FIFO_PTR_BITS;
   localparam int PEND_BITS     = FIFO_PTR_BITS + 2;

   typedef logic signed [SAMPLE_BITS-1:0]                  sample_type;
   typedef logic signed [SAMPLE_BITS:0]                    diff_type;
   typedef logic [WEIGHT_FRAC_BITS:0]                      weight_type;
   typedef logic signed [SAMPLE_BITS+WEIGHT_FRAC_BITS+2:0] product_type;

   // Position of one pending result pixel relative to the image border.
   typedef struct packed {
      logic valid;
      logic top;
      logic bot;
      logic lef;
      logic rig;
      logic last;
   } lane_geo_type;

   typedef struct packed {
      logic                          valid;
      sample_type                    x;
      lane_geo_type [LANES-1:0]      geo;
   } stage1_type;

   // One result pixel with both side differences ready for the multipliers.
   typedef struct packed {
      logic       valid;
      logic       last;
      sample_type pix;
      logic       en_lo;
      diff_type   ba_lo;
      diff_type   pa_lo;
      logic       en_hi;
      diff_type   ba_hi;
      diff_type   pa_hi;
   } lane_type;

   typedef struct packed {
      sample_type thinned;
      logic       suppressed;
      logic       frame_last;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/onms_row_store.sv =====
// ---------------------------------------------------------------------------
// onms_row_store: the two line buffers
// One synchronous memory holds the older and the newer row side by side. Each
// word reads its column, then writes back the rows moved up by one.
// ---------------------------------------------------------------------------
`default_nettype none

module onms_row_store (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [onms_pkg::COL_BITS-1:0] rd_addr,
   input  wire onms_pkg::sample_type          wr_x,
   output onms_pkg::sample_type               older,
   output onms_pkg::sample_type               newer
);

   localparam int PAIR_BITS = 2 * onms_pkg::SAMPLE_BITS;

   logic [PAIR_BITS-1:0] row_mem_ff [onms_pkg::MAX_WIDTH];
   logic [PAIR_BITS-1:0] rd_ff;
   logic [PAIR_BITS-1:0] fwd_ff;
   logic                 fwd_sel_ff;
   logic                 pend_valid_ff;
   logic [onms_pkg::COL_BITS-1:0] pend_addr_ff;
   onms_pkg::sample_type pend_x_ff;

   logic [PAIR_BITS-1:0] pair_eff;
   logic [PAIR_BITS-1:0] wr_pair;

   // A word that reads the column written back in the same cycle takes the
   // write data instead of the stale memory output.
   assign pair_eff = fwd_sel_ff ? fwd_ff : rd_ff;
   assign older    = pair_eff[PAIR_BITS-1:onms_pkg::SAMPLE_BITS];
   assign newer    = pair_eff[onms_pkg::SAMPLE_BITS-1:0];
   assign wr_pair  = {newer, pend_x_ff};

   always_ff @(posedge clock) begin
      if (pend_valid_ff) begin
         row_mem_ff[pend_addr_ff] <= wr_pair;
      end
      if (rd_en) begin
         rd_ff        <= row_mem_ff[rd_addr];
         fwd_ff       <= wr_pair;
         pend_addr_ff <= rd_addr;
         pend_x_ff    <= wr_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         fwd_sel_ff    <= 1'b0;
      end else begin
         pend_valid_ff <= rd_en;
         if (rd_en) begin
            fwd_sel_ff <= pend_valid_ff && (pend_addr_ff == rd_addr);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/onms_window.sv =====
// ---------------------------------------------------------------------------
// onms_window: 3x3 window and neighbour selection
// Shifts the window by one column per word and forms, for each result pixel,
// the two side differences that the sector picks.
// ---------------------------------------------------------------------------
`default_nettype none

module onms_window (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire onms_pkg::stage1_type             s1,
   input  wire onms_pkg::sample_type             older,
   input  wire onms_pkg::sample_type             newer,
   input  wire logic [onms_pkg::SECTOR_BITS-1:0] sector,
   output onms_pkg::lane_type [onms_pkg::LANES-1:0] lanes
);

   typedef onms_pkg::sample_type nbhd_type [0:2][0:2];

   nbhd_type win_ff;
   nbhd_type win_in;
   nbhd_type nb [onms_pkg::LANES];
   onms_pkg::lane_type [onms_pkg::LANES-1:0] lanes_ff;
   onms_pkg::lane_type [onms_pkg::LANES-1:0] lanes_in;

   function automatic onms_pkg::diff_type sub(input onms_pkg::sample_type b,
                                              input onms_pkg::sample_type a);
      sub = onms_pkg::diff_type'(b) - onms_pkg::diff_type'(a);
   endfunction

   function automatic onms_pkg::lane_type build_lane(
      input nbhd_type                      n,
      input onms_pkg::lane_geo_type        g,
      input logic [onms_pkg::SECTOR_BITS-1:0] sec);
      onms_pkg::lane_type   l;
      onms_pkg::sample_type p;
      l       = '0;
      p       = n[1][1];
      l.valid = g.valid;
      l.last  = g.last;
      l.pix   = p;
      case (sec)
         onms_pkg::SECTOR_0: begin
            l.en_lo = g.bot && g.rig;
            l.ba_lo = sub(n[2][2], n[1][2]);
            l.pa_lo = sub(p, n[1][2]);
            l.en_hi = g.top && g.lef;
            l.ba_hi = sub(n[0][0], n[1][0]);
            l.pa_hi = sub(p, n[1][0]);
         end
         onms_pkg::SECTOR_1: begin
            l.en_lo = g.bot && g.rig;
            l.ba_lo = sub(n[2][2], n[2][1]);
            l.pa_lo = sub(p, n[2][1]);
            l.en_hi = g.top && g.lef;
            l.ba_hi = sub(n[0][0], n[0][1]);
            l.pa_hi = sub(p, n[0][1]);
         end
         onms_pkg::SECTOR_2: begin
            l.en_lo = g.bot && g.lef;
            l.ba_lo = sub(n[2][0], n[2][1]);
            l.pa_lo = sub(p, n[2][1]);
            l.en_hi = g.top && g.rig;
            l.ba_hi = sub(n[0][2], n[0][1]);
            l.pa_hi = sub(p, n[0][1]);
         end
         onms_pkg::SECTOR_3: begin
            l.en_lo = g.bot && g.lef;
            l.ba_lo = sub(n[2][0], n[1][0]);
            l.pa_lo = sub(p, n[1][0]);
            l.en_hi = g.top && g.rig;
            l.ba_hi = sub(n[0][2], n[1][2]);
            l.pa_hi = sub(p, n[1][2]);
         end
         default: begin
            l.en_lo = 1'b0;
            l.en_hi = 1'b0;
         end
      endcase
      build_lane = l;
   endfunction

   always_comb begin
      win_in = win_ff;
      if (s1.valid) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i][0] = win_ff[i][1];
            win_in[i][1] = win_ff[i][2];
         end
         win_in[0][2] = older;
         win_in[1][2] = newer;
         win_in[2][2] = s1.x;
      end

      // The four result pixels sit at the window centre, one row down, one
      // column right, or both; neighbours beyond the window read as zero.
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            nb[0][i][j] = win_in[i][j];
            nb[1][i][j] = (i < 2) ? win_in[i+1][j] : '0;
            nb[2][i][j] = (j < 2) ? win_in[i][j+1] : '0;
            nb[3][i][j] = (i < 2 && j < 2) ? win_in[i+1][j+1] : '0;
         end
      end

      for (int k = 0; k < onms_pkg::LANES; k++) begin
         lanes_in[k] = build_lane(nb[k], s1.geo[k], sector);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
         lanes_ff <= '0;
      end else begin
         win_ff   <= win_in;
         lanes_ff <= lanes_in;
      end
   end

   assign lanes = lanes_ff;

endmodule

`default_nettype wire

// ===== hdl/onms_judge.sv =====
// ---------------------------------------------------------------------------
// onms_judge: interpolation products and the suppression decision
// Multiplies each side difference by the weight, registers the products and
// compares them against the scaled pixel difference.
// ---------------------------------------------------------------------------
`default_nettype none

module onms_judge (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire onms_pkg::lane_type [onms_pkg::LANES-1:0] lanes,
   input  wire onms_pkg::weight_type                   weight,
   output logic [onms_pkg::LANES-1:0]                  res_valid,
   output onms_pkg::result_type [onms_pkg::LANES-1:0]  res_data
);

   typedef struct packed {
      logic                  valid;
      logic                  last;
      onms_pkg::sample_type  pix;
      logic                  en_lo;
      logic                  en_hi;
      onms_pkg::diff_type    pa_lo;
      onms_pkg::diff_type    pa_hi;
      onms_pkg::product_type prod_lo;
      onms_pkg::product_type prod_hi;
   } prod_lane_type;

   prod_lane_type [onms_pkg::LANES-1:0] prod_ff;
   prod_lane_type [onms_pkg::LANES-1:0] prod_in;

   logic signed [onms_pkg::WEIGHT_FRAC_BITS+1:0] weight_s;

   assign weight_s = {1'b0, weight};

   // a*(1-d) + b*d > p is rewritten as (b-a)*d > (p-a), one product a side.
   always_comb begin
      for (int k = 0; k < onms_pkg::LANES; k++) begin
         prod_in[k].valid   = lanes[k].valid;
         prod_in[k].last    = lanes[k].last;
         prod_in[k].pix     = lanes[k].pix;
         prod_in[k].en_lo   = lanes[k].en_lo;
         prod_in[k].en_hi   = lanes[k].en_hi;
         prod_in[k].pa_lo   = lanes[k].pa_lo;
         prod_in[k].pa_hi   = lanes[k].pa_hi;
         prod_in[k].prod_lo = onms_pkg::product_type'(lanes[k].ba_lo) *
                              onms_pkg::product_type'(weight_s);
         prod_in[k].prod_hi = onms_pkg::product_type'(lanes[k].ba_hi) *
                              onms_pkg::product_type'(weight_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= '0;
      end else begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      for (int k = 0; k < onms_pkg::LANES; k++) begin
         logic ex_lo;
         logic ex_hi;
         logic sup;
         ex_lo = prod_ff[k].prod_lo >
                 (onms_pkg::product_type'(prod_ff[k].pa_lo) <<< onms_pkg::WEIGHT_FRAC_BITS);
         ex_hi = prod_ff[k].prod_hi >
                 (onms_pkg::product_type'(prod_ff[k].pa_hi) <<< onms_pkg::WEIGHT_FRAC_BITS);
         sup   = (prod_ff[k].en_lo && ex_lo) || (prod_ff[k].en_hi && ex_hi);
         res_valid[k]           = prod_ff[k].valid;
         res_data[k].thinned    = sup ? '0 : prod_ff[k].pix;
         res_data[k].suppressed = sup;
         res_data[k].frame_last = prod_ff[k].last;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/onms_out_fifo.sv =====
// ---------------------------------------------------------------------------
// onms_out_fifo: result queue
// Takes up to four result words a cycle in lane order and hands them out one
// at a time on the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module onms_out_fifo (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic [onms_pkg::LANES-1:0]             push_valid,
   input  wire onms_pkg::result_type [onms_pkg::LANES-1:0] push_data,
   input  wire logic                                   out_stall,
   output logic                                        out_valid,
   output onms_pkg::result_type                        out_data,
   output logic [onms_pkg::FIFO_PTR_BITS:0]            count
);

   onms_pkg::result_type fifo_ff [onms_pkg::FIFO_DEPTH];
   logic [onms_pkg::FIFO_PTR_BITS-1:0] head_ff;
   logic [onms_pkg::FIFO_PTR_BITS-1:0] tail_ff;
   logic [onms_pkg::FIFO_PTR_BITS:0]   count_ff;
   logic [onms_pkg::FIFO_PTR_BITS:0]   count_in;

   logic [onms_pkg::FIFO_PTR_BITS-1:0] slot [onms_pkg::LANES];
   logic [onms_pkg::LANE_CNT_BITS-1:0] npush;
   logic                               pop;

   // Valid lanes are packed behind the tail in lane order.
   always_comb begin
      npush = '0;
      for (int k = 0; k < onms_pkg::LANES; k++) begin
         slot[k] = tail_ff + onms_pkg::FIFO_PTR_BITS'(npush);
         npush   = npush + onms_pkg::LANE_CNT_BITS'(push_valid[k]);
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = fifo_ff[head_ff];
   assign pop       = out_valid && !out_stall;
   assign count_in  = count_ff + (onms_pkg::FIFO_PTR_BITS + 1)'(npush)
                      - (onms_pkg::FIFO_PTR_BITS + 1)'(pop);
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < onms_pkg::LANES; k++) begin
         if (push_valid[k]) begin
            fifo_ff[slot[k]] <= push_data[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         tail_ff  <= tail_ff + onms_pkg::FIFO_PTR_BITS'(npush);
         count_ff <= count_in;
         if (pop) begin
            head_ff <= head_ff + onms_pkg::FIFO_PTR_BITS'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/oriented_nonmax_suppression_top.sv =====
// ---------------------------------------------------------------------------
// oriented_nonmax_suppression_top: interpolated non-maximum suppression
// Thins a raster stream of boundary probabilities against two interpolated
// neighbours taken across the edge direction.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake             word
//   req_      in         req_valid/req_stall   sample
//   rsp_      out        rsp_valid/rsp_stall   thinned, suppressed, frame_last
//   csr_      in         csr_write             csr_index, csr_wdata
//
// One request word is taken per clock unless stalled; a result word passes
// the request, window and product registers to the result queue. On the last
// row a request word yields two result words, the final word of a frame four,
// so there the result port holds the rate to one result word per clock. Reset
// is synchronous; the row memory is not cleared, as no stale entry is used.
// Request stall rises when the queue cannot take four more words in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module oriented_nonmax_suppression_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [onms_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [onms_pkg::SAMPLE_BITS-1:0]  rsp_thinned,
   output logic                                     rsp_suppressed,
   output logic                                     rsp_frame_last,
   input  wire logic                                csr_write,
   input  wire logic [onms_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [onms_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers.
   logic [onms_pkg::DIM_BITS-1:0]        width_ff;
   logic [onms_pkg::DIM_BITS-1:0]        height_ff;
   logic [onms_pkg::SECTOR_BITS-1:0]     sector_ff;
   logic [onms_pkg::WEIGHT_REG_BITS-1:0] weight_ff;

   // Raster position of the next request word.
   logic [onms_pkg::COL_BITS-1:0] col_ff;
   logic [onms_pkg::COL_BITS-1:0] col_in;
   logic [onms_pkg::ROW_BITS-1:0] row_ff;
   logic [onms_pkg::ROW_BITS-1:0] row_in;

   onms_pkg::stage1_type s1_ff;
   onms_pkg::stage1_type s1_in;

   logic                          accept;
   logic [onms_pkg::WCMP_BITS-1:0] w_ext;
   logic [onms_pkg::WCMP_BITS-1:0] eff_w;
   logic [onms_pkg::WCMP_BITS-1:0] c_ext;
   logic [onms_pkg::HCMP_BITS-1:0] h_ext;
   logic [onms_pkg::HCMP_BITS-1:0] eff_h;
   logic [onms_pkg::HCMP_BITS-1:0] r_ext;
   logic                          row_end;
   logic                          last_row;
   logic                          r_ge1, r_ge2, c_ge1, c_ge2;
   logic                          r_in_h, c_in_w;

   logic [onms_pkg::WSAT_BITS-1:0] weight_ext;
   logic [onms_pkg::WSAT_BITS-1:0] weight_one;
   logic [onms_pkg::WSAT_BITS-1:0] weight_sat;
   onms_pkg::weight_type           weight;

   onms_pkg::sample_type older;
   onms_pkg::sample_type newer;
   onms_pkg::lane_type [onms_pkg::LANES-1:0]   lanes;
   logic [onms_pkg::LANES-1:0]                 res_valid;
   onms_pkg::result_type [onms_pkg::LANES-1:0] res_data;
   onms_pkg::result_type                       out_data;
   logic [onms_pkg::FIFO_PTR_BITS:0]           fifo_count;

   logic [onms_pkg::LANE_CNT_BITS-1:0] cnt_s1, cnt_s2, cnt_s3;
   logic [onms_pkg::PEND_BITS-1:0]     pending;

   // -----------------------------------------------------------------------
   // Configuration port. Users write only while pipeline is empty; unenforced.
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= onms_pkg::DIM_BITS'(onms_pkg::MAX_WIDTH);
         height_ff <= onms_pkg::DIM_BITS'(onms_pkg::HEIGHT_LIMIT);
         sector_ff <= '0;
         weight_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            onms_pkg::REG_IMAGE_WIDTH:      width_ff  <= csr_wdata[onms_pkg::DIM_BITS-1:0];
            onms_pkg::REG_IMAGE_HEIGHT:     height_ff <= csr_wdata[onms_pkg::DIM_BITS-1:0];
            onms_pkg::REG_DIRECTION_SECTOR: sector_ff <= csr_wdata[onms_pkg::SECTOR_BITS-1:0];
            onms_pkg::REG_INTERP_WEIGHT:    weight_ff <= csr_wdata[onms_pkg::WEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Weights above one saturate to exactly one.
   assign weight_ext = onms_pkg::WSAT_BITS'(weight_ff);
   assign weight_one = onms_pkg::WSAT_BITS'(1) << onms_pkg::WEIGHT_FRAC_BITS;
   assign weight_sat = (weight_ext > weight_one) ? weight_one : weight_ext;
   assign weight     = weight_sat[onms_pkg::WEIGHT_FRAC_BITS:0];

   // -----------------------------------------------------------------------
   // Request stage: raster counters, border flags and the row memory read.
   // A zero width or height counts as one; the width is capped at the line
   // buffer length and the height at the range of the row counter.
   // -----------------------------------------------------------------------
   always_comb begin
      w_ext = onms_pkg::WCMP_BITS'(width_ff);
      if (w_ext == '0) begin
         eff_w = onms_pkg::WCMP_BITS'(1);
      end else if (w_ext > onms_pkg::WCMP_BITS'(onms_pkg::MAX_WIDTH)) begin
         eff_w = onms_pkg::WCMP_BITS'(onms_pkg::MAX_WIDTH);
      end else begin
         eff_w = w_ext;
      end

      h_ext = onms_pkg::HCMP_BITS'(height_ff);
      if (h_ext == '0) begin
         eff_h = onms_pkg::HCMP_BITS'(1);
      end else if (h_ext > onms_pkg::HCMP_BITS'(onms_pkg::HEIGHT_LIMIT)) begin
         eff_h = onms_pkg::HCMP_BITS'(onms_pkg::HEIGHT_LIMIT);
      end else begin
         eff_h = h_ext;
      end
   end

   assign accept   = req_valid && !req_stall;
   assign c_ext    = onms_pkg::WCMP_BITS'(col_ff);
   assign r_ext    = onms_pkg::HCMP_BITS'(row_ff);
   assign row_end  = (c_ext + onms_pkg::WCMP_BITS'(1)) >= eff_w;
   assign last_row = (r_ext + onms_pkg::HCMP_BITS'(1)) >= eff_h;
   assign r_ge1    = (row_ff != '0);
   assign r_ge2    = (row_ff > onms_pkg::ROW_BITS'(1));
   assign c_ge1    = (col_ff != '0);
   assign c_ge2    = (col_ff > onms_pkg::COL_BITS'(1));
   assign r_in_h   = (r_ext < eff_h);
   assign c_in_w   = (c_ext < eff_w);

   // Four possible results, in output order: the pixel one row up and one
   // column left; on the last row the pixel one column left; at the row's
   // end the pixel one row up in this column; and at the frame's end this
   // pixel itself.
   always_comb begin
      s1_in.valid = accept;
      s1_in.x     = req_sample;

      s1_in.geo[0].valid = accept && r_ge1 && c_ge1;
      s1_in.geo[0].top   = r_ge2;
      s1_in.geo[0].bot   = r_in_h;
      s1_in.geo[0].lef   = c_ge2;
      s1_in.geo[0].rig   = c_in_w;
      s1_in.geo[0].last  = 1'b0;

      s1_in.geo[1].valid = accept && last_row && c_ge1;
      s1_in.geo[1].top   = r_ge1;
      s1_in.geo[1].bot   = !last_row;
      s1_in.geo[1].lef   = c_ge2;
      s1_in.geo[1].rig   = c_in_w;
      s1_in.geo[1].last  = 1'b0;

      s1_in.geo[2].valid = accept && r_ge1 && row_end;
      s1_in.geo[2].top   = r_ge2;
      s1_in.geo[2].bot   = r_in_h;
      s1_in.geo[2].lef   = c_ge1;
      s1_in.geo[2].rig   = !row_end;
      s1_in.geo[2].last  = 1'b0;

      s1_in.geo[3].valid = accept && last_row && row_end;
      s1_in.geo[3].top   = r_ge1;
      s1_in.geo[3].bot   = !last_row;
      s1_in.geo[3].lef   = c_ge1;
      s1_in.geo[3].rig   = !row_end;
      s1_in.geo[3].last  = 1'b1;
   end

   // The frame ends after the last column of the last row; the counters then
   // start the next frame.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + onms_pkg::ROW_BITS'(1);
         end else begin
            col_in = col_ff + onms_pkg::COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_ff  <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         s1_ff  <= s1_in;
      end
   end

   onms_row_store u_row_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_x    (req_sample),
      .older   (older),
      .newer   (newer)
   );

   // -----------------------------------------------------------------------
   // Window, multiply and compare stages, then the result queue.
   // -----------------------------------------------------------------------
   onms_window u_window (
      .clock  (clock),
      .reset  (reset),
      .s1     (s1_ff),
      .older  (older),
      .newer  (newer),
      .sector (sector_ff),
      .lanes  (lanes)
   );

   onms_judge u_judge (
      .clock     (clock),
      .reset     (reset),
      .lanes     (lanes),
      .weight    (weight),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   onms_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_data  (res_data),
      .out_stall  (rsp_stall),
      .out_valid  (rsp_valid),
      .out_data   (out_data),
      .count      (fifo_count)
   );

   assign rsp_thinned    = out_data.thinned;
   assign rsp_suppressed = out_data.suppressed;
   assign rsp_frame_last = out_data.frame_last;

   // -----------------------------------------------------------------------
   // Credit: every result word still in the pipeline has a queue entry held
   // for it, so the pipeline itself never has to stop.
   // -----------------------------------------------------------------------
   always_comb begin
      cnt_s1 = '0;
      cnt_s2 = '0;
      cnt_s3 = '0;
      for (int k = 0; k < onms_pkg::LANES; k++) begin
         cnt_s1 = cnt_s1 + onms_pkg::LANE_CNT_BITS'(s1_ff.geo[k].valid);
         cnt_s2 = cnt_s2 + onms_pkg::LANE_CNT_BITS'(lanes[k].valid);
         cnt_s3 = cnt_s3 + onms_pkg::LANE_CNT_BITS'(res_valid[k]);
      end
      pending = onms_pkg::PEND_BITS'(fifo_count) + onms_pkg::PEND_BITS'(cnt_s1)
                + onms_pkg::PEND_BITS'(cnt_s2) + onms_pkg::PEND_BITS'(cnt_s3);
   end

   assign req_stall = pending > onms_pkg::PEND_BITS'(onms_pkg::FIFO_DEPTH - onms_pkg::LANES);

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for oriented non-maximum suppression
// Streams frames of boundary-probability words through the block, predicts
// every thinned pixel with a behavioural model of the window and row buffers,
// and compares each result word field by field in arrival order. Both channels
// idle and stall at random, and the configuration changes between frames.
// ---------------------------------------------------------------------------

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   // Sectors four to seven switch suppression off; four is the documented one.
   localparam logic [onms_pkg::SECTOR_BITS-1:0] SECTOR_NONE = onms_pkg::SECTOR_BITS'(4);
   localparam int RANDOM_ITEMS = 380;
   localparam int QUIET_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 10;

   // -------------------------------------------------------------------------
   // Behavioural model of the thinning pipeline plus the queue of pixels that
   // the block still owes us. Row buffers, window and counters mirror the
   // block's own state so that every accepted word can be replayed here.
   // -------------------------------------------------------------------------
   class thinning_scoreboard;
      logic [onms_pkg::DIM_BITS-1:0]        width_reg;
      logic [onms_pkg::DIM_BITS-1:0]        height_reg;
      logic [onms_pkg::SECTOR_BITS-1:0]     sector_reg;
      logic [onms_pkg::WEIGHT_REG_BITS-1:0] weight_reg;
      onms_pkg::sample_type                 upper_row [onms_pkg::MAX_WIDTH];
      onms_pkg::sample_type                 middle_row [onms_pkg::MAX_WIDTH];
      onms_pkg::sample_type                 window [3][3];
      longint                               hood [3][3];
      int unsigned                          row_count;
      int unsigned                          col_count;
      onms_pkg::result_type                 awaited_pixels [$];
      int unsigned                          mismatch_count;

      function new();
         width_reg  = onms_pkg::DIM_BITS'(onms_pkg::MAX_WIDTH);
         height_reg = onms_pkg::DIM_BITS'(onms_pkg::HEIGHT_LIMIT);
         sector_reg = onms_pkg::SECTOR_0;
         weight_reg = '0;
         foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
         end
         foreach (window[i, j]) window[i][j] = '0;
         row_count      = 0;
         col_count      = 0;
         mismatch_count = 0;
      endfunction

      function void set_register(logic [onms_pkg::CSR_INDEX_BITS-1:0] index,
                                 logic [onms_pkg::CSR_DATA_BITS-1:0] value);
         case (index)
            onms_pkg::REG_IMAGE_WIDTH:
               width_reg  = value[onms_pkg::DIM_BITS-1:0];
            onms_pkg::REG_IMAGE_HEIGHT:
               height_reg = value[onms_pkg::DIM_BITS-1:0];
            onms_pkg::REG_DIRECTION_SECTOR:
               sector_reg = value[onms_pkg::SECTOR_BITS-1:0];
            onms_pkg::REG_INTERP_WEIGHT:
               weight_reg = value[onms_pkg::WEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Exact comparison of a*(1-d) + b*d against the centre, scaled by 2^F.
      function bit exceeds(longint near_val, longint far_val, longint centre);
         longint one;
         longint d;
         one = longint'(1) << onms_pkg::WEIGHT_FRAC_BITS;
         d   = longint'(weight_reg);
         if (d > one) d = one;
         return near_val * (one - d) + far_val * d > centre * one;
      endfunction

      // Copy the 3x3 neighbourhood, offset into the window, padding with zero.
      function void load_hood(int unsigned row_off, int unsigned col_off);
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               hood[i][j] = (i + row_off < 3 && j + col_off < 3) ?
                            longint'(window[i + row_off][j + col_off]) : 0;
      endfunction

      function onms_pkg::result_type thin_pixel(int unsigned row_at, int unsigned col_at,
                                                int unsigned cols, int unsigned rows,
                                                bit last);
         bit                   top;
         bit                   bot;
         bit                   lef;
         bit                   rig;
         bit                   hit;
         onms_pkg::result_type res;
         top = row_at > 0;
         bot = row_at + 1 < rows;
         lef = col_at > 0;
         rig = col_at + 1 < cols;
         case (sector_reg)
            onms_pkg::SECTOR_0:
               hit = (bot && rig && exceeds(hood[1][2], hood[2][2], hood[1][1])) ||
                     (top && lef && exceeds(hood[1][0], hood[0][0], hood[1][1]));
            onms_pkg::SECTOR_1:
               hit = (bot && rig && exceeds(hood[2][1], hood[2][2], hood[1][1])) ||
                     (top && lef && exceeds(hood[0][1], hood[0][0], hood[1][1]));
            onms_pkg::SECTOR_2:
               hit = (bot && lef && exceeds(hood[2][1], hood[2][0], hood[1][1])) ||
                     (top && rig && exceeds(hood[0][1], hood[0][2], hood[1][1]));
            onms_pkg::SECTOR_3:
               hit = (bot && lef && exceeds(hood[1][0], hood[2][0], hood[1][1])) ||
                     (top && rig && exceeds(hood[1][2], hood[0][2], hood[1][1]));
            default:
               hit = 1'b0;
         endcase
         res.thinned    = hit ? '0 : onms_pkg::sample_type'(hood[1][1]);
         res.suppressed = hit;
         res.frame_last = last;
         return res;
      endfunction

      // Replay one accepted word: shift the window, update the row buffers and
      // queue the pixels that this word completes, in the block's lane order.
      function void note_sample(onms_pkg::sample_type value);
         int unsigned cols;
         int unsigned rows;
         int unsigned r;
         int unsigned c;
         int unsigned slot;
         bit          row_end;
         bit          last_row;
         cols = (width_reg == 0) ? 1 :
                ((width_reg > onms_pkg::MAX_WIDTH) ? onms_pkg::MAX_WIDTH : width_reg);
         rows = (height_reg == 0) ? 1 :
                ((height_reg > onms_pkg::HEIGHT_LIMIT) ? onms_pkg::HEIGHT_LIMIT : height_reg);
         r        = row_count;
         c        = col_count;
         slot     = (c < onms_pkg::MAX_WIDTH) ? c : onms_pkg::MAX_WIDTH - 1;
         row_end  = (c + 1 >= cols) || (c + 1 >= onms_pkg::MAX_WIDTH);
         last_row = r + 1 >= rows;
         for (int i = 0; i < 3; i++) begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
         end
         window[0][2]     = upper_row[slot];
         window[1][2]     = middle_row[slot];
         window[2][2]     = value;
         upper_row[slot]  = middle_row[slot];
         middle_row[slot] = value;
         if (r >= 1 && c >= 1) begin
            load_hood(0, 0);
            awaited_pixels.push_back(thin_pixel(r - 1, c - 1, cols, rows, 1'b0));
         end
         if (last_row && c >= 1) begin
            load_hood(1, 0);
            awaited_pixels.push_back(thin_pixel(r, c - 1, cols, rows, 1'b0));
         end
         if (r >= 1 && row_end) begin
            load_hood(0, 1);
            awaited_pixels.push_back(thin_pixel(r - 1, c, cols, rows, 1'b0));
         end
         if (last_row && row_end) begin
            load_hood(1, 1);
            awaited_pixels.push_back(thin_pixel(r, c, cols, rows, 1'b1));
         end
         if (row_end) begin
            col_count = 0;
            row_count = last_row ? 0 : (r + 1) % onms_pkg::HEIGHT_LIMIT;
         end else begin
            col_count = c + 1;
         end
      endfunction

      function void check_result(onms_pkg::sample_type thinned, logic suppressed,
                                 logic frame_last);
         onms_pkg::result_type want;
         if (awaited_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result word: thinned=%0d suppressed=%b frame_last=%b",
                        thinned, suppressed, frame_last);
         end else begin
            want = awaited_pixels.pop_front();
            if (want.thinned !== thinned || want.suppressed !== suppressed ||
                want.frame_last !== frame_last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result mismatch: expected %0d/%b/%b, got %0d/%b/%b",
                           want.thinned, want.suppressed, want.frame_last,
                           thinned, suppressed, frame_last);
            end
         end
      endfunction

      function int unsigned pending();
         return awaited_pixels.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, block inputs and outputs. Every input has a known value from time
   // zero; reset is held high at the start and then released for good.
   // -------------------------------------------------------------------------
   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_valid  = 1'b0;
   logic                                req_stall;
   onms_pkg::sample_type                req_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_stall  = 1'b0;
   onms_pkg::sample_type                rsp_thinned;
   logic                                rsp_suppressed;
   logic                                rsp_frame_last;
   logic                                csr_write  = 1'b0;
   logic [onms_pkg::CSR_INDEX_BITS-1:0] csr_index  = onms_pkg::REG_IMAGE_WIDTH;
   logic [onms_pkg::CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   thinning_scoreboard sb;

   // Per-frame switches that take the random idling out for a whole frame.
   bit          req_steady  = 1'b0;
   bit          rsp_steady  = 1'b0;
   int unsigned frame_level = 0;
   int unsigned random_items = 0;
   int unsigned stall_left  = 0;
   int unsigned quiet_cycles = 0;

   onms_pkg::sample_type corner_values [0:8] = '{16'sh7FFF, 16'sh8000, 16'sh0000,
                                                 16'shFFFF, 16'sh0001, 16'sh4000,
                                                 16'shC000, 16'sh7FFE, 16'sh8001};

   always #5 clock = ~clock;

   oriented_nonmax_suppression_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_thinned    (rsp_thinned),
      .rsp_suppressed (rsp_suppressed),
      .rsp_frame_last (rsp_frame_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Result side. Outputs are read at the rising edge, so the values seen are
   // the ones the block presented for that edge. After each accepted word the
   // receiver draws a random stall, unless the frame is steady.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_thinned, rsp_suppressed, rsp_frame_last);
         stall_left = rsp_steady ? 0 : $urandom_range(0, 10);
         rsp_stall <= (stall_left != 0);
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   // The run is abandoned when neither channel nor the register port has moved
   // a word for far longer than any legal gap, stall or pause could last.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Mostly values clustered round a per-frame level, so that neighbours are
   // close and the interpolation decides; the rest full-range or extremes.
   function automatic onms_pkg::sample_type pick_sample();
      case ($urandom_range(0, 5))
         0: return onms_pkg::sample_type'($urandom);
         1: return corner_values[$urandom_range(0, $size(corner_values) - 1)];
         default: return onms_pkg::sample_type'(frame_level + $urandom_range(0, 64) - 32);
      endcase
   endfunction

   // One register write; the write enable is dropped again before the task returns.
   task automatic write_reg(input logic [onms_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [onms_pkg::CSR_DATA_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(index, value);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned cols, input int unsigned rows,
                            input int unsigned sector, input int unsigned weight);
      write_reg(onms_pkg::REG_IMAGE_WIDTH, onms_pkg::CSR_DATA_BITS'(cols));
      write_reg(onms_pkg::REG_IMAGE_HEIGHT, onms_pkg::CSR_DATA_BITS'(rows));
      write_reg(onms_pkg::REG_DIRECTION_SECTOR, onms_pkg::CSR_DATA_BITS'(sector));
      write_reg(onms_pkg::REG_INTERP_WEIGHT, onms_pkg::CSR_DATA_BITS'(weight));
   endtask

   // Offer one word after a random gap and hold it until the block takes it.
   // Valid is left high on acceptance so that back-to-back words need only a
   // single assignment at that edge.
   task automatic send_sample(input onms_pkg::sample_type value);
      int unsigned gap;
      gap = req_steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(value);
   endtask

   // Drop valid, wait for every owed pixel, then allow the pipeline to empty
   // fully before anything touches the registers.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned cols;
      int unsigned rows;
      int unsigned sector;
      int unsigned weight;

      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // A 3x3 frame of extreme values under the reset sector and weight.
      write_reg(onms_pkg::REG_IMAGE_WIDTH, onms_pkg::CSR_DATA_BITS'(3));
      write_reg(onms_pkg::REG_IMAGE_HEIGHT, onms_pkg::CSR_DATA_BITS'(3));
      foreach (corner_values[k]) send_sample(corner_values[k]);
      settle();

      // Zero sizes behave as one, so each word is a frame of its own; the
      // weight is above one and the sector disables suppression.
      configure(0, 0, SECTOR_NONE, (1 << onms_pkg::WEIGHT_REG_BITS) - 1);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      settle();

      // Weight exactly one: the far neighbour alone decides.
      configure(2, 2, onms_pkg::SECTOR_1, 1 << onms_pkg::WEIGHT_FRAC_BITS);
      send_sample(16'sh1000);
      send_sample(16'sh3000);
      send_sample(16'sh2000);
      send_sample(16'sh4000);
      settle();

      // Oversized frame, then shrunk while idle: the width drops below the
      // current column, which ends the first row early, and later the height
      // drops below the current row, which makes it the last one.
      configure((1 << onms_pkg::DIM_BITS) - 1, (1 << onms_pkg::DIM_BITS) - 1,
                onms_pkg::SECTOR_2, 'h0C000);
      frame_level = $urandom;
      repeat (4) send_sample(pick_sample());
      settle();
      write_reg(onms_pkg::REG_IMAGE_WIDTH, onms_pkg::CSR_DATA_BITS'(2));
      repeat (3) send_sample(pick_sample());
      settle();
      write_reg(onms_pkg::REG_DIRECTION_SECTOR, onms_pkg::CSR_DATA_BITS'(onms_pkg::SECTOR_3));
      write_reg(onms_pkg::REG_IMAGE_HEIGHT, onms_pkg::CSR_DATA_BITS'(1));
      repeat (2) send_sample(pick_sample());
      settle();

      // Random frames: small sizes, every sector code and a spread of weights,
      // with idling switched off on either side for about a quarter of them.
      while (random_items < RANDOM_ITEMS) begin
         req_steady  = ($urandom_range(0, 3) == 0);
         rsp_steady  = ($urandom_range(0, 3) == 0);
         frame_level = $urandom;
         cols = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 24) : $urandom_range(0, 10);
         rows = $urandom_range(0, 5);
         sector = ($urandom_range(0, 4) == 0) ?
                  SECTOR_NONE + $urandom_range(0, 3) :
                  $urandom_range(onms_pkg::SECTOR_0, onms_pkg::SECTOR_3);
         case ($urandom_range(0, 3))
            0: weight = 0;
            1: weight = 1 << onms_pkg::WEIGHT_FRAC_BITS;
            2: weight = $urandom_range(0, 1 << onms_pkg::WEIGHT_FRAC_BITS);
            default: weight = $urandom;
         endcase
         configure(cols, rows, sector, weight);
         repeat (((cols == 0) ? 1 : cols) * ((rows == 0) ? 1 : rows)) begin
            send_sample(pick_sample());
            random_items++;
         end
         settle();
      end

      if (sb.mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== oriented_nonmax_suppression_top.f =====
hdl/onms_pkg.sv
hdl/onms_row_store.sv
hdl/onms_window.sv
hdl/onms_judge.sv
hdl/onms_out_fifo.sv
hdl/oriented_nonmax_suppression_top.sv
dv/tb_top.sv
